[src/kmeans_assign_and_update_unit_macros.svh]
// Assertion helpers for the k-means assign and update unit.
`ifndef KMEANS_ASSIGN_AND_UPDATE_UNIT_MACROS_SVH
`define KMEANS_ASSIGN_AND_UPDATE_UNIT_MACROS_SVH

// Same-cycle implication.
`define KMAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication.
`define KMAU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

[src/kmau_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmau_pkg
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package kmau_pkg;

    localparam int MAX_CLUSTERS_DEF   = 64;
    localparam int MAX_DIMENSIONS_DEF = 128;
    localparam int COUNT_BITS_DEF     = 20;

    localparam int VAL_W      = 16;
    localparam int DIST_W     = 40;
    localparam int OUT_DIST_W = 39;
    localparam int SQ_W       = 34;
    localparam int SUM_W      = 37;
    localparam int DIVD_W     = 37;
    localparam int ACT_W      = 2;
    localparam int CI_PORT_W  = 6;
    localparam int EI_PORT_W  = 7;
    localparam int PREV_W     = 7;
    localparam int KCFG_W     = 7;
    localparam int DCFG_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD   = 2'd0,
        ACT_POINT  = 2'd1,
        ACT_UPDATE = 2'd2,
        ACT_NONE   = 2'd3
    } act_t;

    localparam logic [CFG_IDX_W-1:0] REG_CLUSTERS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DIMS     = 1'b1;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LATCH,
        OP_LOAD,
        OP_BUF_WR,
        OP_PD_RD,
        OP_PD_MUL,
        OP_PD_ACC,
        OP_MIN_RD,
        OP_MIN_CMP,
        OP_EMIT,
        OP_AC_RD,
        OP_AC_WR,
        OP_CNT_RD,
        OP_CNT_WR,
        OP_RC_CNT_RD,
        OP_RC_SUM_RD,
        OP_DIV_START,
        OP_RC_WR,
        OP_RC_CLR
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   c_clr;
        logic   c_inc;
        logic   e_clr;
        logic   e_inc;
    } dp_cmd_t;

    typedef struct packed {
        act_t action;
        logic last;
        logic in_range;
        logic c_done;
        logic e_done;
        logic e_act_last;
        logic row_valid;
        logic div_done;
        logic out_busy;
    } dp_stat_t;

endpackage

[src/kmau_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmau_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kmau_div
    import kmau_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVD_W-1:0]     dividend,
    input  logic [COUNT_BITS-1:0] divisor,
    output logic                  done,
    output logic [DIVD_W-1:0]     quotient
);

    localparam int STEP_W = $clog2(DIVD_W + 1);

    logic [COUNT_BITS:0]   rem_reg;
    logic [DIVD_W-1:0]     quo_reg;
    logic [COUNT_BITS-1:0] dvs_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [COUNT_BITS:0]   shifted;
    logic                  fits;

    assign shifted  = {rem_reg[COUNT_BITS-1:0], quo_reg[DIVD_W-1]};
    assign fits     = shifted >= {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DIVD_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (shifted - {1'b0, dvs_reg}) : shifted;
            quo_reg <= {quo_reg[DIVD_W-2:0], fits};
        end
    end

endmodule

[src/kmau_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmau_dp
// Datapath: centroid, distance, buffer, sum and count stores plus arithmetic.
// ----------------------------------------------------------------------------
module kmau_dp
    import kmau_pkg::*;
#(
    parameter int MAX_CLUSTERS   = MAX_CLUSTERS_DEF,
    parameter int MAX_DIMENSIONS = MAX_DIMENSIONS_DEF,
    parameter int COUNT_BITS     = COUNT_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  dp_cmd_t                      cmd,
    output dp_stat_t                     stat,
    input  logic                         cfg_valid,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic [ACT_W-1:0]             action,
    input  logic [CI_PORT_W-1:0]         cluster_index,
    input  logic [EI_PORT_W-1:0]         element_index,
    input  logic signed [VAL_W-1:0]      element_value,
    input  logic signed [PREV_W-1:0]     previous_cluster,
    input  logic                         last_element,
    input  logic                         out_stall,
    output logic                         out_valid,
    output logic [CI_PORT_W-1:0]         nearest_cluster,
    output logic [OUT_DIST_W-1:0]        nearest_distance,
    output logic                         membership_changed
);

    localparam int CI_W  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int EI_W  = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;
    localparam int DEPTH = MAX_CLUSTERS * MAX_DIMENSIONS;
    localparam int CA_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [VAL_W-1:0]      cent_mem [DEPTH];
    logic [DIST_W-1:0]     pd_mem   [MAX_CLUSTERS];
    logic [VAL_W-1:0]      buf_mem  [MAX_DIMENSIONS];
    logic [SUM_W-1:0]      sum_mem  [DEPTH];
    logic [COUNT_BITS-1:0] cnt_mem  [MAX_CLUSTERS];

    logic [MAX_CLUSTERS-1:0] pdv_reg;
    logic [MAX_CLUSTERS-1:0] rowv_reg;

    logic [KCFG_W-1:0]     k_cfg_reg;
    logic [DCFG_W-1:0]     d_cfg_reg;
    logic [ACT_W-1:0]      act_reg;
    logic [CI_PORT_W-1:0]  ci_reg;
    logic [EI_PORT_W-1:0]  ei_reg;
    logic [VAL_W-1:0]      val_reg;
    logic [PREV_W-1:0]     prev_reg;
    logic                  last_reg;
    logic [CI_W-1:0]       c_reg;
    logic [EI_W-1:0]       e_reg;
    logic [VAL_W-1:0]      cent_q_reg;
    logic [DIST_W-1:0]     pd_q_reg;
    logic [VAL_W-1:0]      buf_q_reg;
    logic [SUM_W-1:0]      sum_q_reg;
    logic [COUNT_BITS-1:0] cnt_q_reg;
    logic [SQ_W-1:0]       sq_reg;
    logic [CI_W-1:0]       best_c_reg;
    logic [DIST_W-1:0]     best_d_reg;
    logic                  neg_reg;
    logic                  out_valid_reg;
    logic [CI_PORT_W-1:0]  out_c_reg;
    logic [OUT_DIST_W-1:0] out_d_reg;
    logic                  out_chg_reg;

    logic [CI_W-1:0]       k_last;
    logic [EI_W-1:0]       d_last;
    logic [EI_W-1:0]       ei_idx;
    logic [CI_W-1:0]       row_c;
    logic [CA_W-1:0]       pt_addr;
    logic [CA_W-1:0]       ld_addr;
    logic [CA_W-1:0]       rc_addr;
    logic [CA_W-1:0]       ac_addr;
    logic                  load_ok;
    logic signed [VAL_W:0] diff;
    logic signed [2*VAL_W+1:0] prod;
    logic [DIST_W-1:0]     pd_old;
    logic [DIST_W:0]       pd_acc;
    logic [DIST_W-1:0]     pd_new;
    logic [SUM_W-1:0]      sum_old;
    logic [SUM_W:0]        sum_acc;
    logic [SUM_W-1:0]      sum_sat;
    logic [SUM_W-1:0]      sum_new;
    logic [COUNT_BITS-1:0] cnt_old;
    logic [SUM_W-1:0]      sum_mag;
    logic [DIVD_W-1:0]     dividend;
    logic                  div_start;
    logic                  div_done;
    logic [DIVD_W-1:0]     quot;
    logic [VAL_W:0]        q_clamp;
    logic [VAL_W-1:0]      rc_val;
    logic                  cent_we;

    always_comb
    begin
        if (k_cfg_reg == '0)
            k_last = '0;
        else if (32'(k_cfg_reg) > MAX_CLUSTERS)
            k_last = CI_W'(MAX_CLUSTERS - 1);
        else
            k_last = CI_W'(32'(k_cfg_reg) - 1);
        if (d_cfg_reg == '0)
            d_last = '0;
        else if (32'(d_cfg_reg) > MAX_DIMENSIONS)
            d_last = EI_W'(MAX_DIMENSIONS - 1);
        else
            d_last = EI_W'(32'(d_cfg_reg) - 1);
    end

    assign ei_idx  = EI_W'(ei_reg);
    assign row_c   = (cmd.op == OP_AC_RD || cmd.op == OP_AC_WR) ? best_c_reg : c_reg;
    assign pt_addr = CA_W'(32'(c_reg) * MAX_DIMENSIONS + 32'(ei_idx));
    assign ld_addr = CA_W'(32'(ci_reg) * MAX_DIMENSIONS + 32'(ei_reg));
    assign rc_addr = CA_W'(32'(c_reg) * MAX_DIMENSIONS + 32'(e_reg));
    assign ac_addr = CA_W'(32'(row_c) * MAX_DIMENSIONS + 32'(e_reg));
    assign load_ok = (32'(ci_reg) < MAX_CLUSTERS) && (32'(ei_reg) < MAX_DIMENSIONS);

    // distance step
    assign diff   = {val_reg[VAL_W-1], val_reg} - {cent_q_reg[VAL_W-1], cent_q_reg};
    assign prod   = diff * diff;
    assign pd_old = pdv_reg[c_reg] ? pd_q_reg : '0;
    assign pd_acc = {1'b0, pd_old} + (DIST_W+1)'(sq_reg);
    assign pd_new = pd_acc[DIST_W] ? {DIST_W{1'b1}} : pd_acc[DIST_W-1:0];

    // sum accumulate with saturation
    assign sum_old = rowv_reg[best_c_reg] ? sum_q_reg : '0;
    assign sum_acc = {sum_old[SUM_W-1], sum_old}
                   + {{(SUM_W+1-VAL_W){buf_q_reg[VAL_W-1]}}, buf_q_reg};
    assign sum_sat = (sum_acc[SUM_W] != sum_acc[SUM_W-1])
                   ? (sum_acc[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                     : {1'b0, {(SUM_W-1){1'b1}}})
                   : sum_acc[SUM_W-1:0];
    assign sum_new = (e_reg <= d_last) ? sum_sat : sum_old;
    assign cnt_old = rowv_reg[best_c_reg] ? cnt_q_reg : '0;

    // recompute
    assign sum_mag   = sum_q_reg[SUM_W-1] ? (~sum_q_reg + 1'b1) : sum_q_reg;
    assign dividend  = DIVD_W'(sum_mag) + DIVD_W'(cnt_q_reg >> 1);
    assign div_start = (cmd.op == OP_DIV_START);
    assign q_clamp   = (quot > DIVD_W'(32768)) ? (VAL_W+1)'(32768) : quot[VAL_W:0];
    assign rc_val    = neg_reg ? VAL_W'(~q_clamp + 1'b1)
                               : (q_clamp[VAL_W] ? {1'b0, {(VAL_W-1){1'b1}}}
                                                 : q_clamp[VAL_W-1:0]);

    kmau_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (cnt_q_reg),
        .done     (div_done),
        .quotient (quot)
    );

    assign cent_we = (cmd.op == OP_LOAD && load_ok) || (cmd.op == OP_RC_WR);

    always_ff @(posedge clk)
    begin
        if (cent_we)
            cent_mem[(cmd.op == OP_LOAD) ? ld_addr : rc_addr] <=
                (cmd.op == OP_LOAD) ? val_reg : rc_val;
        if (cmd.op == OP_PD_RD)
            cent_q_reg <= cent_mem[pt_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_PD_ACC)
            pd_mem[c_reg] <= pd_new;
        if (cmd.op == OP_PD_RD || cmd.op == OP_MIN_RD)
            pd_q_reg <= pd_mem[c_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_BUF_WR)
            buf_mem[ei_idx] <= val_reg;
        if (cmd.op == OP_AC_RD)
            buf_q_reg <= buf_mem[e_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_AC_WR)
            sum_mem[ac_addr] <= sum_new;
        if (cmd.op == OP_AC_RD || cmd.op == OP_RC_SUM_RD)
            sum_q_reg <= sum_mem[ac_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_CNT_WR)
            cnt_mem[best_c_reg] <= (&cnt_old) ? cnt_old : cnt_old + 1'b1;
        if (cmd.op == OP_CNT_RD)
            cnt_q_reg <= cnt_mem[best_c_reg];
        else if (cmd.op == OP_RC_CNT_RD)
            cnt_q_reg <= cnt_mem[c_reg];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LATCH)
        begin
            act_reg  <= action;
            ci_reg   <= cluster_index;
            ei_reg   <= element_index;
            val_reg  <= element_value;
            prev_reg <= previous_cluster;
            last_reg <= last_element;
        end
        if (cmd.op == OP_PD_MUL)
            sq_reg <= SQ_W'($unsigned(prod));
        if (cmd.op == OP_MIN_CMP && (c_reg == '0 || pd_old < best_d_reg))
        begin
            best_d_reg <= pd_old;
            best_c_reg <= c_reg;
        end
        if (cmd.op == OP_DIV_START)
            neg_reg <= sum_q_reg[SUM_W-1];
        if (cmd.op == OP_EMIT)
        begin
            out_c_reg   <= CI_PORT_W'(best_c_reg);
            out_d_reg   <= best_d_reg[DIST_W-1] ? {OUT_DIST_W{1'b1}}
                                                : best_d_reg[OUT_DIST_W-1:0];
            out_chg_reg <= prev_reg[PREV_W-1]
                         || (32'(prev_reg[PREV_W-2:0]) != 32'(best_c_reg));
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_cfg_reg     <= KCFG_W'(1);
            d_cfg_reg     <= DCFG_W'(1);
            c_reg         <= '0;
            e_reg         <= '0;
            pdv_reg       <= '0;
            rowv_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_CLUSTERS: k_cfg_reg <= cfg_data[KCFG_W-1:0];
                    REG_DIMS:     d_cfg_reg <= cfg_data[DCFG_W-1:0];
                    default:      ;
                endcase
            end
            if (cmd.c_clr)
                c_reg <= '0;
            else if (cmd.c_inc)
                c_reg <= c_reg + 1'b1;
            if (cmd.e_clr)
                e_reg <= '0;
            else if (cmd.e_inc)
                e_reg <= e_reg + 1'b1;
            if (cmd.op == OP_PD_ACC)
                pdv_reg[c_reg] <= 1'b1;
            if (cmd.op == OP_CNT_WR)
            begin
                pdv_reg              <= '0;
                rowv_reg[best_c_reg] <= 1'b1;
            end
            if (cmd.op == OP_RC_CLR)
                rowv_reg <= '0;
            if (cmd.op == OP_EMIT)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        stat.action     = act_t'(act_reg);
        stat.last       = last_reg;
        stat.in_range   = 32'(ei_reg) <= 32'(d_last);
        stat.c_done     = (c_reg == k_last);
        stat.e_done     = (e_reg == EI_W'(MAX_DIMENSIONS - 1));
        stat.e_act_last = (e_reg == d_last);
        stat.row_valid  = rowv_reg[c_reg];
        stat.div_done   = div_done;
        stat.out_busy   = out_valid_reg && out_stall;
    end

    assign out_valid          = out_valid_reg;
    assign nearest_cluster    = out_c_reg;
    assign nearest_distance   = out_d_reg;
    assign membership_changed = out_chg_reg;

endmodule

[src/kmau_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmau_ctrl
// Sequencer for load, point element, nearest search, accumulate and update.
// ----------------------------------------------------------------------------
module kmau_ctrl
    import kmau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_PD_RD,
        S_PD_MUL,
        S_PD_ACC,
        S_MIN_RD,
        S_MIN_CMP,
        S_EMIT,
        S_AC_RD,
        S_AC_WR,
        S_CNT_RD,
        S_CNT_WR,
        S_RC_ROW,
        S_RC_CHK,
        S_RC_RD,
        S_RC_DIV,
        S_RC_WAIT,
        S_RC_END
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '{op: OP_NOP, c_clr: 1'b0, c_inc: 1'b0, e_clr: 1'b0, e_inc: 1'b0};
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.action)
                    ACT_LOAD:
                    begin
                        cmd.op     = OP_LOAD;
                        state_next = S_IDLE;
                    end
                    ACT_UPDATE:
                    begin
                        cmd.c_clr  = 1'b1;
                        state_next = S_RC_ROW;
                    end
                    ACT_POINT:
                    begin
                        cmd.c_clr = 1'b1;
                        if (stat.in_range)
                        begin
                            cmd.op     = OP_BUF_WR;
                            state_next = S_PD_RD;
                        end
                        else if (stat.last)
                            state_next = S_MIN_RD;
                        else
                            state_next = S_IDLE;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_PD_RD:
            begin
                cmd.op     = OP_PD_RD;
                state_next = S_PD_MUL;
            end
            S_PD_MUL:
            begin
                cmd.op     = OP_PD_MUL;
                state_next = S_PD_ACC;
            end
            S_PD_ACC:
            begin
                cmd.op = OP_PD_ACC;
                if (!stat.c_done)
                begin
                    cmd.c_inc  = 1'b1;
                    state_next = S_PD_RD;
                end
                else if (stat.last)
                begin
                    cmd.c_clr  = 1'b1;
                    state_next = S_MIN_RD;
                end
                else
                    state_next = S_IDLE;
            end
            S_MIN_RD:
            begin
                cmd.op     = OP_MIN_RD;
                state_next = S_MIN_CMP;
            end
            S_MIN_CMP:
            begin
                cmd.op = OP_MIN_CMP;
                if (stat.c_done)
                begin
                    cmd.e_clr  = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.c_inc  = 1'b1;
                    state_next = S_MIN_RD;
                end
            end
            S_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_AC_RD;
                end
            end
            S_AC_RD:
            begin
                cmd.op     = OP_AC_RD;
                state_next = S_AC_WR;
            end
            S_AC_WR:
            begin
                cmd.op = OP_AC_WR;
                if (stat.e_done)
                    state_next = S_CNT_RD;
                else
                begin
                    cmd.e_inc  = 1'b1;
                    state_next = S_AC_RD;
                end
            end
            S_CNT_RD:
            begin
                cmd.op     = OP_CNT_RD;
                state_next = S_CNT_WR;
            end
            S_CNT_WR:
            begin
                cmd.op     = OP_CNT_WR;
                state_next = S_IDLE;
            end
            S_RC_ROW:
            begin
                cmd.op     = OP_RC_CNT_RD;
                state_next = S_RC_CHK;
            end
            S_RC_CHK:
            begin
                if (stat.row_valid)
                begin
                    cmd.e_clr  = 1'b1;
                    state_next = S_RC_RD;
                end
                else if (stat.c_done)
                    state_next = S_RC_END;
                else
                begin
                    cmd.c_inc  = 1'b1;
                    state_next = S_RC_ROW;
                end
            end
            S_RC_RD:
            begin
                cmd.op     = OP_RC_SUM_RD;
                state_next = S_RC_DIV;
            end
            S_RC_DIV:
            begin
                cmd.op     = OP_DIV_START;
                state_next = S_RC_WAIT;
            end
            S_RC_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.op = OP_RC_WR;
                    if (!stat.e_act_last)
                    begin
                        cmd.e_inc  = 1'b1;
                        state_next = S_RC_RD;
                    end
                    else if (stat.c_done)
                        state_next = S_RC_END;
                    else
                    begin
                        cmd.c_inc  = 1'b1;
                        state_next = S_RC_ROW;
                    end
                end
            end
            S_RC_END:
            begin
                cmd.op     = OP_RC_CLR;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

[src/kmeans_assign_and_update_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmeans_assign_and_update_unit
// Lloyd k-means engine: nearest-centroid assignment and centroid update.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one action per beat: centroid
// element load, point element, or centroid recompute. Output channel
// (out_valid / out_stall) carries one beat per finished point: nearest
// cluster, its squared distance and a membership change flag. Config port
// (cfg_valid / cfg_ready, always ready) sets active clusters and dimensions.
// One action is worked at a time; in_stall is high while it runs.
// A point element in the active range runs the per-cluster centroid read,
// multiply and distance accumulate sequence over the K active clusters.
// The last element adds a minimum search over the clusters, the result beat
// and a sum and count accumulate over all MAX_DIMENSIONS buffer elements.
// Recompute runs the bit-serial divider once per active element of each
// non-empty cluster.
// A stalled result register holds its beat; the next point's result waits
// for it. Reset empties all sums, counts and distances at once; centroids
// and the point buffer hold nothing until written.
// ----------------------------------------------------------------------------
module kmeans_assign_and_update_unit
    import kmau_pkg::*;
#(
    parameter int MAX_CLUSTERS   = MAX_CLUSTERS_DEF,
    parameter int MAX_DIMENSIONS = MAX_DIMENSIONS_DEF,
    parameter int COUNT_BITS     = COUNT_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [ACT_W-1:0]         action,
    input  logic [CI_PORT_W-1:0]     cluster_index,
    input  logic [EI_PORT_W-1:0]     element_index,
    input  logic signed [VAL_W-1:0]  element_value,
    input  logic signed [PREV_W-1:0] previous_cluster,
    input  logic                     last_element,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [CI_PORT_W-1:0]     nearest_cluster,
    output logic [OUT_DIST_W-1:0]    nearest_distance,
    output logic                     membership_changed,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    kmau_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    kmau_dp #(
        .MAX_CLUSTERS   (MAX_CLUSTERS),
        .MAX_DIMENSIONS (MAX_DIMENSIONS),
        .COUNT_BITS     (COUNT_BITS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .cfg_valid          (cfg_valid && cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .action             (action),
        .cluster_index      (cluster_index),
        .element_index      (element_index),
        .element_value      (element_value),
        .previous_cluster   (previous_cluster),
        .last_element       (last_element),
        .out_stall          (out_stall),
        .out_valid          (out_valid),
        .nearest_cluster    (nearest_cluster),
        .nearest_distance   (nearest_distance),
        .membership_changed (membership_changed)
    );

endmodule

[src/kmau_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmau_checker
// Port-level checks for the k-means assign and update unit.
// ----------------------------------------------------------------------------
`include "kmeans_assign_and_update_unit_macros.svh"

module kmau_checker
    import kmau_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic [ACT_W-1:0]         action,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic                     cfg_valid,
    input logic                     cfg_ready
);

    `KMAU_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `KMAU_ASSERT_NXT(a_busy_after_beat, clk, rst_n, in_valid && !in_stall, in_stall)
    `KMAU_ASSERT_NXT(a_no_result_nonpoint, clk, rst_n, in_valid && !in_stall && action != ACT_POINT && !out_valid, !out_valid)
    `KMAU_ASSERT_IMP(a_cfg_idle_ok, clk, rst_n, cfg_valid && !in_stall, cfg_ready)

endmodule

bind kmeans_assign_and_update_unit kmau_checker u_kmau_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
